FILE: design/fsie_pkg.sv
package fsie_pkg;

  localparam int DATA_W    = 32;
  localparam int OPC_W     = 8;
  localparam int OPND_W    = 16;
  localparam int STAT_W    = 3;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  // Operation codes.
  localparam logic [OPC_W-1:0] OP_HALT = 8'h00;
  localparam logic [OPC_W-1:0] OP_STI  = 8'h01;
  localparam logic [OPC_W-1:0] OP_STR  = 8'h02;
  localparam logic [OPC_W-1:0] OP_LDP  = 8'h03;
  localparam logic [OPC_W-1:0] OP_LDM  = 8'h04;
  localparam logic [OPC_W-1:0] OP_LDI  = 8'h05;
  localparam logic [OPC_W-1:0] OP_MOV  = 8'h06;
  localparam logic [OPC_W-1:0] OP_WAIT = 8'h07;
  localparam logic [OPC_W-1:0] OP_AND  = 8'h0A;
  localparam logic [OPC_W-1:0] OP_OR   = 8'h0B;
  localparam logic [OPC_W-1:0] OP_ADD  = 8'h0C;
  localparam logic [OPC_W-1:0] OP_SUB  = 8'h0D;
  localparam logic [OPC_W-1:0] OP_JNE  = 8'h0E;
  localparam logic [OPC_W-1:0] OP_STP  = 8'h11;
  localparam logic [OPC_W-1:0] OP_SHL  = 8'h13;
  localparam logic [OPC_W-1:0] OP_SHR  = 8'h14;
  localparam logic [OPC_W-1:0] OP_JUNK = 8'h17;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_HALT   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_WAIT   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_JMP = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_OP  = 3'd4;

  // One decoded instruction as it travels through the block.
  typedef struct packed {
    logic [OPC_W-1:0]     opcode;
    logic [REG_IDX_W-1:0] dest_index;
    logic [OPND_W-1:0]    second_operand;
    logic [DATA_W-1:0]    immediate;
  } instr_t;

endpackage

FILE: design/fsie_in_if.sv
interface fsie_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [fsie_pkg::OPC_W-1:0]           opcode;
  logic [fsie_pkg::REG_IDX_W-1:0]       dest_index;
  logic [fsie_pkg::OPND_W-1:0]          second_operand;
  logic [fsie_pkg::DATA_W-1:0]          immediate;

  modport source (output valid, output opcode, output dest_index, output second_operand,
                  output immediate, input ready);
  modport sink   (input valid, input opcode, input dest_index, input second_operand,
                  input immediate, output ready);
endinterface

FILE: design/fsie_out_if.sv
interface fsie_out_if;
  logic                          valid;
  logic                          ready;
  logic [fsie_pkg::DATA_W-1:0]   next_pc;
  logic [fsie_pkg::STAT_W-1:0]   status;

  modport source (output valid, output next_pc, output status, input ready);
  modport sink   (input valid, input next_pc, input status, output ready);
endinterface

FILE: design/fsie_ram.sv
module fsie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/flash_sequencer_instruction_executor_top.sv
// Flash sequencer instruction executor.
// in_ch carries one decoded instruction per beat (opcode, dest_index,
// second_operand, immediate); out_ch returns one beat per instruction with
// the program counter that follows it and a status code, in input order.
// Eight 32-bit registers sit in two copies of a small RAM so that two
// operands are read together; data words sit in one RAM of MEM_WORDS
// entries with a registered read.
// Register and jump instructions pass through S_EX and S_FIN; register
// stores add S_MEM, loads add S_MEM and S_LD, and the immediate store adds
// S_MEM and S_ST, whose four word writes share the single memory write port.
// When MEM_WORDS is not a power of two, every memory instruction also passes
// through S_MOD, which reduces the word index by reciprocal multiplication.
// One instruction waits in an input buffer while another executes, and the
// finished result waits in an output register; a stalled out_ch holds the
// executing instruction at its last step and fills the input buffer.
// After reset the registers and program counter read zero; data memory is
// undefined until written.
module flash_sequencer_instruction_executor_top #(
  parameter int MEM_WORDS = 16384
) (
  input  logic      clk,
  input  logic      rst_n,
  fsie_in_if.sink   in_ch,
  fsie_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MEM_WORDS);
  localparam bit POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam logic [IDX_W:0] MEM_W1 = (IDX_W + 1)'(MEM_WORDS);
  localparam int ADDR_W = fsie_pkg::DATA_W - 2;
  localparam int RECIP_SH = ADDR_W;
  localparam logic [ADDR_W-1:0] RECIP = ADDR_W'((64'd1 << RECIP_SH) / 64'(MEM_WORDS));
  localparam logic [ADDR_W-1:0] MEM_WA = ADDR_W'(MEM_WORDS);
  localparam logic [1:0] MOD_LAST = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EX   = 7'b0000010,
    S_MOD  = 7'b0000100,
    S_MEM  = 7'b0001000,
    S_LD   = 7'b0010000,
    S_ST   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Input buffer and the executing instruction.
  logic                  buf_valid_r;
  fsie_pkg::instr_t      buf_r;
  fsie_pkg::instr_t      cur_r;
  logic [fsie_pkg::REG_IDX_W-1:0] rb_sel_r;

  // Register file.
  logic [fsie_pkg::NUM_REGS-1:0]  rf_valid_r;
  logic [fsie_pkg::REG_IDX_W-1:0] rb_addr;
  logic [fsie_pkg::DATA_W-1:0]    ra_rdata, rb_rdata, ra_val, rb_val;
  logic [fsie_pkg::DATA_W-1:0]    opa_r;
  logic                           rf_we;
  logic [fsie_pkg::DATA_W-1:0]    rf_wdata;

  // Data memory.
  logic [IDX_W-1:0]            midx_r;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [fsie_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
  logic [1:0]                  step_r;
  logic [IDX_W:0]              dec_ext, dec_k;
  logic [IDX_W-1:0]            dec_idx;

  // Index reduction.
  logic [ADDR_W-1:0]   addr_raw, mval_r;
  logic [ADDR_W-1:0]   quot_r, qm_r;
  logic [2*ADDR_W-1:0] recip_prod;
  logic [ADDR_W-1:0]   qm_prod;
  logic [ADDR_W-1:0]   rem_diff;
  logic [IDX_W:0]      rem_est;
  logic [1:0]          cnt_r;
  logic [IDX_W-1:0]    rem_nxt;

  // Execute results.
  logic [fsie_pkg::DATA_W-1:0] pc_r, pc_nxt;
  logic [fsie_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic                        mem_op;
  logic                        ex_we;
  logic [fsie_pkg::DATA_W-1:0] ex_wdata;

  // Output register.
  logic                        out_valid_r;
  logic [fsie_pkg::DATA_W-1:0] out_pc_r;
  logic [fsie_pkg::STAT_W-1:0] out_st_r;

  logic slot_free, start, accept, finish;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign finish    = (state_r == S_FIN) && slot_free;
  assign start     = buf_valid_r && ((state_r == S_IDLE) || finish);
  assign in_ch.ready = !buf_valid_r || start;
  assign accept    = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.next_pc = out_pc_r;
  assign out_ch.status  = out_st_r;

  // The jump reads its target register on the second port.
  assign rb_addr = (buf_r.opcode == fsie_pkg::OP_JNE) ? buf_r.immediate[2:0]
                                                       : buf_r.second_operand[2:0];

  fsie_ram #(.WIDTH(fsie_pkg::DATA_W), .DEPTH(fsie_pkg::NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (cur_r.dest_index),
    .wdata (rf_wdata),
    .raddr (buf_r.dest_index),
    .rdata (ra_rdata)
  );

  fsie_ram #(.WIDTH(fsie_pkg::DATA_W), .DEPTH(fsie_pkg::NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (cur_r.dest_index),
    .wdata (rf_wdata),
    .raddr (rb_addr),
    .rdata (rb_rdata)
  );

  fsie_ram #(.WIDTH(fsie_pkg::DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (midx_r),
    .rdata (mem_rdata)
  );

  // A register never written since reset reads as zero.
  assign ra_val = rf_valid_r[cur_r.dest_index] ? ra_rdata : '0;
  assign rb_val = rf_valid_r[rb_sel_r] ? rb_rdata : '0;

  always_comb begin
    pc_nxt   = pc_r + 32'd8;
    stat_nxt = fsie_pkg::STAT_DONE;
    mem_op   = 1'b0;
    ex_we    = 1'b0;
    ex_wdata = ra_val;
    unique case (cur_r.opcode)
      fsie_pkg::OP_HALT: begin
        pc_nxt   = pc_r;
        stat_nxt = fsie_pkg::STAT_HALT;
      end
      fsie_pkg::OP_STI, fsie_pkg::OP_STR, fsie_pkg::OP_LDP,
      fsie_pkg::OP_LDM, fsie_pkg::OP_STP: begin
        mem_op = 1'b1;
      end
      fsie_pkg::OP_LDI: begin
        ex_we    = 1'b1;
        ex_wdata = cur_r.immediate;
      end
      fsie_pkg::OP_MOV: begin
        ex_we    = 1'b1;
        ex_wdata = rb_val;
      end
      fsie_pkg::OP_WAIT: begin
        stat_nxt = fsie_pkg::STAT_WAIT;
      end
      fsie_pkg::OP_AND: begin
        ex_we    = 1'b1;
        ex_wdata = ra_val & rb_val & cur_r.immediate;
      end
      fsie_pkg::OP_OR: begin
        ex_we    = 1'b1;
        ex_wdata = ra_val | rb_val | cur_r.immediate;
      end
      fsie_pkg::OP_ADD: begin
        ex_we    = 1'b1;
        ex_wdata = rb_val + cur_r.immediate;
      end
      fsie_pkg::OP_SUB: begin
        ex_we    = 1'b1;
        ex_wdata = rb_val - cur_r.immediate;
      end
      fsie_pkg::OP_JNE: begin
        // A taken jump still gets the usual 8-byte advance.
        if (ra_val != {16'b0, cur_r.second_operand}) begin
          pc_nxt = rb_val + 32'd8;
        end
      end
      fsie_pkg::OP_SHL: begin
        ex_we    = 1'b1;
        ex_wdata = (|cur_r.immediate[31:5]) ? '0 : rb_val << cur_r.immediate[4:0];
      end
      fsie_pkg::OP_SHR: begin
        ex_we    = 1'b1;
        ex_wdata = (|cur_r.immediate[31:5]) ? '0 : rb_val >> cur_r.immediate[4:0];
      end
      fsie_pkg::OP_JUNK: begin
        stat_nxt = fsie_pkg::STAT_BAD_JMP;
      end
      default: begin
        stat_nxt = fsie_pkg::STAT_BAD_OP;
      end
    endcase
  end

  // Word index before reduction: byte pointers from registers or the operand.
  always_comb begin
    if (cur_r.opcode == fsie_pkg::OP_LDP) begin
      addr_raw = ra_val[31:2];
    end else if (cur_r.opcode == fsie_pkg::OP_STP) begin
      addr_raw = rb_val[31:2];
    end else begin
      addr_raw = {16'b0, cur_r.second_operand[15:2]};
    end
  end

  // The reciprocal estimate of the quotient is at most one short, so the
  // remainder needs a single compare and subtract at the end.
  assign recip_prod = mval_r * RECIP;
  assign qm_prod    = quot_r * MEM_WA;
  assign rem_diff   = mval_r - qm_r;
  assign rem_est    = rem_diff[IDX_W:0];
  assign rem_nxt    = (rem_est >= MEM_W1) ? IDX_W'(rem_est - MEM_W1) : rem_est[IDX_W-1:0];

  // Descending store index, wrapping below zero.
  assign dec_ext = {1'b0, midx_r};
  assign dec_k   = (IDX_W + 1)'(step_r);
  assign dec_idx = (dec_ext >= dec_k) ? IDX_W'(dec_ext - dec_k)
                                      : IDX_W'(dec_ext + MEM_W1 - dec_k);

  always_comb begin
    rf_we     = 1'b0;
    rf_wdata  = ex_wdata;
    mem_we    = 1'b0;
    mem_waddr = midx_r;
    mem_wdata = opa_r;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EX;
        end
      end
      S_EX: begin
        rf_we = ex_we;
        if (!mem_op) begin
          state_nxt = S_FIN;
        end else if (POW2) begin
          state_nxt = S_MEM;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (cnt_r == '0) begin
          state_nxt = S_MEM;
        end
      end
      S_MEM: begin
        if (cur_r.opcode == fsie_pkg::OP_STI) begin
          mem_we    = 1'b1;
          mem_wdata = cur_r.immediate;
          state_nxt = S_ST;
        end else if (cur_r.opcode == fsie_pkg::OP_STR || cur_r.opcode == fsie_pkg::OP_STP) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_LD;
        end
      end
      S_LD: begin
        rf_we     = 1'b1;
        rf_wdata  = (cur_r.opcode == fsie_pkg::OP_LDP) ? mem_rdata
                                                        : mem_rdata & cur_r.immediate;
        state_nxt = S_FIN;
      end
      S_ST: begin
        mem_we    = 1'b1;
        mem_waddr = dec_idx;
        mem_wdata = cur_r.immediate >> {step_r, 3'b000};
        if (step_r == 2'd3) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_nxt = start ? S_EX : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buf_valid_r <= 1'b0;
      rf_valid_r  <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        buf_valid_r <= 1'b1;
      end else if (start) begin
        buf_valid_r <= 1'b0;
      end
      if (rf_we) begin
        rf_valid_r[cur_r.dest_index] <= 1'b1;
      end
      if (state_r == S_EX) begin
        pc_r <= pc_nxt;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r.opcode         <= in_ch.opcode;
      buf_r.dest_index     <= in_ch.dest_index;
      buf_r.second_operand <= in_ch.second_operand;
      buf_r.immediate      <= in_ch.immediate;
    end
    if (start) begin
      cur_r    <= buf_r;
      rb_sel_r <= rb_addr;
    end
    if (state_r == S_EX) begin
      stat_r <= stat_nxt;
      opa_r  <= ra_val;
      midx_r <= addr_raw[IDX_W-1:0];
      mval_r <= addr_raw;
      cnt_r  <= MOD_LAST;
    end
    // Quotient, its product and the remainder settle one step apart.
    if (state_r == S_MOD) begin
      quot_r <= recip_prod[2*ADDR_W-1:RECIP_SH];
      qm_r   <= qm_prod;
      cnt_r  <= cnt_r - 2'd1;
      if (cnt_r == '0) begin
        midx_r <= rem_nxt;
      end
    end
    if (state_r == S_MEM) begin
      step_r <= 2'd1;
    end else if (state_r == S_ST) begin
      step_r <= step_r + 2'd1;
    end
    if (finish) begin
      out_pc_r <= pc_r;
      out_st_r <= stat_r;
    end
  end

endmodule

FILE: test/fsie_exec_check.sv
module fsie_exec_check #(
  parameter int MEM_WORDS = 16384
) (
  input  logic clk,
  input  logic rst_n,
  fsie_in_if   in_mon,
  fsie_out_if  out_mon,
  output int   errors,
  output int   pending
);
  import fsie_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    logic [STAT_W-1:0] status;
  } exec_result_t;

  logic [DATA_W-1:0] regs [NUM_REGS];
  logic [DATA_W-1:0] word_mem [MEM_WORDS];
  logic [DATA_W-1:0] pc;
  exec_result_t      expected_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Word index of a store or load, stepped back by some words and wrapped
  // into the memory.
  function automatic int word_index(logic [DATA_W-1:0] word, int back);
    longint idx;
    idx = longint'(word) % MEM_WORDS;
    return int'((idx + MEM_WORDS - back) % MEM_WORDS);
  endfunction

  function automatic exec_result_t execute_instr(instr_t ins);
    logic [REG_IDX_W-1:0] d;
    logic [REG_IDX_W-1:0] s;
    logic [DATA_W-1:0]    imm;
    logic [DATA_W-1:0]    opnd_word;
    int                   w;
    exec_result_t         res;
    d          = ins.dest_index;
    s          = ins.second_operand[REG_IDX_W-1:0];
    imm        = ins.immediate;
    opnd_word  = ins.second_operand >> 2;
    w          = word_index(opnd_word, 0);
    res.status = STAT_DONE;
    case (ins.opcode)
      OP_HALT: res.status = STAT_HALT;
      OP_STI: begin
        for (int k = 0; k < 4; k++)
          word_mem[word_index(opnd_word, k)] = imm >> (8 * k);
      end
      OP_STR:  word_mem[w] = regs[d];
      OP_LDP:  regs[d] = word_mem[word_index(regs[d] >> 2, 0)];
      OP_LDM:  regs[d] = word_mem[w] & imm;
      OP_LDI:  regs[d] = imm;
      OP_MOV:  regs[d] = regs[s];
      OP_WAIT: res.status = STAT_WAIT;
      OP_AND:  regs[d] = regs[d] & regs[s] & imm;
      OP_OR:   regs[d] = regs[d] | regs[s] | imm;
      OP_ADD:  regs[d] = regs[s] + imm;
      OP_SUB:  regs[d] = regs[s] - imm;
      OP_JNE: begin
        if (regs[d] != DATA_W'(ins.second_operand))
          pc = regs[imm[REG_IDX_W-1:0]];
      end
      OP_STP:  word_mem[word_index(regs[s] >> 2, 0)] = regs[d];
      OP_SHL:  regs[d] = (imm >= DATA_W) ? '0 : regs[s] << imm;
      OP_SHR:  regs[d] = (imm >= DATA_W) ? '0 : regs[s] >> imm;
      OP_JUNK: res.status = STAT_BAD_JMP;
      default: res.status = STAT_BAD_OP;
    endcase
    // A taken jump still gets the 8-byte advance; only halt holds the pc.
    if (ins.opcode != OP_HALT)
      pc = pc + 8;
    res.next_pc = pc;
    return res;
  endfunction

  always @(posedge clk) begin
    instr_t       ins;
    exec_result_t want;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        ins.opcode         = in_mon.opcode;
        ins.dest_index     = in_mon.dest_index;
        ins.second_operand = in_mon.second_operand;
        ins.immediate      = in_mon.immediate;
        expected_q.push_back(execute_instr(ins));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: next_pc %h status %0d",
                   $time, out_mon.next_pc, out_mon.status);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.next_pc !== want.next_pc) begin
            $display("%0t: next_pc expected %h, got %h", $time, want.next_pc,
                     out_mon.next_pc);
            errors++;
          end
          if (out_mon.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_mon.status);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: test/flash_sequencer_instruction_executor_top_tb.sv
module flash_sequencer_instruction_executor_top_tb;
  import fsie_pkg::*;

  localparam int MEM_WORDS    = 16384;
  localparam int RANDOM_ITEMS = 1950;

  localparam logic [REG_IDX_W-1:0] R0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] R1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] R2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] R3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] R4 = 3'd4;
  localparam logic [REG_IDX_W-1:0] R5 = 3'd5;
  localparam logic [REG_IDX_W-1:0] R6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] R7 = 3'd7;

  localparam logic [OPC_W-1:0] OP_UNUSED_LO = 8'h08;
  localparam logic [OPC_W-1:0] OP_UNUSED_HI = 8'hFF;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  logic     clk          = 1'b0;
  logic     rst_n        = 1'b0;
  logic     result_ready = 1'b0;
  int       fail_count;
  int       pending_results;
  int       burst_left   = 0;
  int       items_issued = 0;
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_count     = 0;

  // Words known to hold data; loads only ever point at these.
  bit       mem_written [MEM_WORDS];
  int       written_words [$];

  fsie_in_if  in_ch();
  fsie_out_if out_ch();

  assign out_ch.ready = result_ready;

  flash_sequencer_instruction_executor_top #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  fsie_exec_check #(.MEM_WORDS(MEM_WORDS)) exec_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_mon (in_ch),
    .out_mon(out_ch),
    .errors (fail_count),
    .pending(pending_results)
  );

  always #5 clk = ~clk;

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk) begin
    rx_count++;
    if (rx_count % 50 == 0)
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   result_ready <= 1'b1;
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default:   result_ready <= (rx_count % 20 >= 15);
    endcase
  end

  function automatic void mark_written(int idx);
    if (!mem_written[idx]) begin
      mem_written[idx] = 1'b1;
      written_words.push_back(idx);
    end
  endfunction

  function automatic int any_written();
    return written_words[$urandom_range(0, written_words.size() - 1)];
  endfunction

  // Byte address whose word index lands on idx, with random upper bits that
  // the block has to wrap away.
  function automatic logic [DATA_W-1:0] pointer_to(int idx);
    int unsigned       k;
    logic [DATA_W-1:0] word_no;
    k       = $urandom_range(0, ((1 << 30) - 1 - idx) / MEM_WORDS);
    word_no = k * MEM_WORDS + idx;
    return {word_no[29:0], 2'($urandom_range(0, 3))};
  endfunction

  function automatic logic [DATA_W-1:0] shift_amount();
    case ($urandom_range(0, 5))
      0:       return DATA_W'($urandom_range(32, 40));
      1:       return $urandom;
      default: return DATA_W'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic issue(input logic [OPC_W-1:0] op, input logic [REG_IDX_W-1:0] d,
                       input logic [OPND_W-1:0] opnd, input logic [DATA_W-1:0] imm);
    int base;
    base = (opnd >> 2) % MEM_WORDS;
    if (op == OP_STI)
      for (int k = 0; k < 4; k++) mark_written((base + MEM_WORDS - k) % MEM_WORDS);
    if (op == OP_STR)
      mark_written(base);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.dest_index     <= d;
    in_ch.second_operand <= opnd;
    in_ch.immediate      <= imm;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_issued++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  task automatic random_step();
    int                   pick;
    logic [REG_IDX_W-1:0] d;
    logic [OPND_W-1:0]    opnd;
    logic [DATA_W-1:0]    imm;
    logic [OPC_W-1:0]     op;
    pick = $urandom_range(0, 99);
    d    = REG_IDX_W'($urandom);
    opnd = OPND_W'($urandom);
    imm  = $urandom;
    if (pick < 12 || (pick >= 12 && pick < 18)) begin
      // Keep half the stores in a small window so later loads overlap them.
      if ($urandom_range(0, 1) == 0)
        opnd = OPND_W'($urandom_range(0, 255));
      issue((pick < 12) ? OP_STI : OP_STR, d, opnd, imm);
    end else if (pick < 26) begin
      issue(OP_LDM, d, {(OPND_W-2)'(any_written()), 2'($urandom_range(0, 3))}, imm);
    end else if (pick < 32) begin
      issue(OP_LDI, d, opnd, pointer_to(any_written()));
      issue(OP_LDP, d, OPND_W'($urandom), $urandom);
    end else if (pick < 40) begin
      if ($urandom_range(0, 1) == 0)
        imm = DATA_W'($urandom_range(0, 65535));
      issue(OP_LDI, d, opnd, imm);
    end else if (pick < 46) begin
      issue(OP_MOV, d, opnd, imm);
    end else if (pick < 52) begin
      issue(OP_AND, d, opnd, imm);
    end else if (pick < 58) begin
      issue(OP_OR, d, opnd, imm);
    end else if (pick < 65) begin
      issue(OP_ADD, d, opnd, imm);
    end else if (pick < 70) begin
      issue(OP_SUB, d, opnd, imm);
    end else if (pick < 78) begin
      // Half the jumps compare against a value just loaded, so they fall through.
      if ($urandom_range(0, 1) == 0)
        issue(OP_LDI, d, OPND_W'($urandom), DATA_W'(opnd));
      issue(OP_JNE, d, opnd, imm);
    end else if (pick < 83) begin
      issue(OP_STP, d, opnd, imm);
    end else if (pick < 88) begin
      issue(OP_SHL, d, opnd, shift_amount());
    end else if (pick < 93) begin
      issue(OP_SHR, d, opnd, shift_amount());
    end else if (pick < 95) begin
      issue(OP_WAIT, d, opnd, imm);
    end else if (pick < 96) begin
      issue(OP_HALT, d, opnd, imm);
    end else if (pick < 97) begin
      issue(OP_JUNK, d, opnd, imm);
    end else begin
      op = OPC_W'($urandom);
      if (op == OP_LDP || op == OP_LDM)
        op ^= 8'h80;
      issue(op, d, opnd, imm);
    end
  endtask

  initial begin
    int target;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_HALT;
    in_ch.dest_index     = R0;
    in_ch.second_operand = '0;
    in_ch.immediate      = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Stores at the top of memory and at word zero, where the descending
    // store wraps below zero.
    issue(OP_STI, R0, 16'hFFFF, 32'hA5C3_1E7F);
    issue(OP_STI, R7, 16'h0000, 32'hFFFF_FFFF);
    issue(OP_LDI, R1, 16'hFFFF, 32'hFFFF_FFFF);
    issue(OP_LDI, R2, 16'h0000, 32'h0000_0000);
    issue(OP_STR, R1, 16'h0010, 32'h0000_0000);
    issue(OP_LDM, R3, 16'h0013, 32'hFFFF_FFFF);
    issue(OP_LDM, R4, 16'hFFFF, 32'h0000_FFFF);
    // Pointer far past the end of memory wraps onto the last word.
    issue(OP_LDI, R5, 16'h0000, 32'hFFFF_FFFC);
    issue(OP_LDP, R5, 16'hFFFF, 32'hFFFF_FFFF);
    issue(OP_MOV, R6, {13'h1FFF, R1}, 32'h0000_0000);
    issue(OP_AND, R6, {13'h0000, R1}, 32'hF0F0_F0F0);
    issue(OP_OR,  R2, {13'h1FFF, R2}, 32'h8000_0001);
    issue(OP_ADD, R7, {13'h0000, R1}, 32'h0000_0001);
    issue(OP_SUB, R0, {13'h0000, R0}, 32'hFFFF_FFFF);
    issue(OP_SHL, R3, {13'h0000, R1}, 32'd31);
    issue(OP_SHL, R3, {13'h0000, R1}, 32'd32);
    issue(OP_SHR, R4, {13'h1FFF, R1}, 32'hFFFF_FFFF);
    issue(OP_SHR, R4, {13'h0000, R1}, 32'd0);
    issue(OP_STP, R1, {13'h0000, R5}, 32'h0000_0000);
    issue(OP_LDI, R6, 16'h0000, 32'h0000_FFFF);
    issue(OP_JNE, R6, 16'hFFFF, 32'h0000_0000);
    // Taken jump to the top of the address space; the advance wraps to zero.
    issue(OP_LDI, R5, 16'h0000, 32'hFFFF_FFF8);
    issue(OP_JNE, R1, 16'h0000, {29'h1FFF_FFFF, R5});
    issue(OP_WAIT, R2, 16'h1234, 32'h0000_0000);
    issue(OP_JUNK, R3, 16'h0000, 32'h0000_0000);
    issue(OP_HALT, R4, 16'h0000, 32'h0000_0000);
    issue(OP_UNUSED_HI, R7, 16'hFFFF, 32'hFFFF_FFFF);
    issue(OP_UNUSED_LO, R0, 16'h0000, 32'h0000_0000);
    drain();

    target = items_issued + RANDOM_ITEMS;
    while (items_issued < target) begin
      random_step();
      if ($urandom_range(0, 199) == 0)
        drain();
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
